// File: sv/mwo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-waveform oscillator package
// Widths, register indexes, waveform codes and reset values shared by the
// oscillator top level, its sine ROM and its channel interfaces.
// ----------------------------------------------------------------------------
package mwo_pkg;

   localparam int unsigned SAMPLE_W    = 24;   // mix_in / mix_out, signed Q1.23
   localparam int unsigned SINE_W      = 23;   // quarter-wave table entry
   localparam int unsigned PHASE_W     = 32;
   localparam int unsigned STEP_W      = 31;
   localparam int unsigned AMP_W       = 16;
   localparam int unsigned WAVE_W      = 2;
   localparam int unsigned CHAN_W      = 4;
   localparam int unsigned CHAN_CMP_W  = 5;    // holds a channel count up to 16
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 31;   // widest register: phase_step
   localparam int unsigned VAL_W       = 26;   // oscillator value and sums, signed
   localparam int unsigned MAG_W       = 24;   // oscillator magnitude, up to 2^23
   localparam int unsigned PROD_W      = 40;   // magnitude times amplitude

   localparam int unsigned SINE_TABLE_SIZE = 1024;
   localparam int unsigned MAX_CHANNELS    = 8;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic signed [63:0] MAX_Q23_64 = 64'sd8388607;

   localparam logic signed [VAL_W-1:0] FULL_Q23 = 26'sd8388608;
   localparam logic signed [VAL_W-1:0] TRI_TOP  = 26'sd25165824;   // three times full scale
   localparam logic signed [VAL_W-1:0] SAT_MAX  = 26'sd8388607;
   localparam logic signed [VAL_W-1:0] SAT_MIN  = -26'sd8388608;
   localparam logic [PROD_W-1:0]       ROUND_HALF = 40'd32768;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP    = 3'd0,
      CSR_AMPLITUDE     = 3'd1,
      CSR_WAVEFORM      = 3'd2,
      CSR_TONE_ENABLE   = 3'd3,
      CSR_CHANNEL_COUNT = 3'd4
   } csr_index_type;

   typedef enum logic [WAVE_W-1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_TRIANGLE = 2'd1,
      WAVE_SAW      = 2'd2,
      WAVE_SQUARE   = 2'd3
   } wave_type;

   localparam logic [STEP_W-1:0] PHASE_STEP_RST    = 31'd39370534;
   localparam logic [AMP_W-1:0]  AMPLITUDE_RST     = 16'd6554;
   localparam logic              TONE_ENABLE_RST   = 1'b1;
   localparam logic [CHAN_W-1:0] CHANNEL_COUNT_RST = 4'd2;

endpackage

// File: sv/mwo_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oscillator request channel
// Valid/ready channel that carries one buffer sample per transaction.
// ----------------------------------------------------------------------------
interface mwo_req_if;

   logic                                  valid;
   logic                                  ready;
   logic signed [mwo_pkg::SAMPLE_W-1:0]   mix_in;
   logic                                  last_in;

   modport source (
      output valid,
      output mix_in,
      output last_in,
      input  ready
   );

   modport sink (
      input  valid,
      input  mix_in,
      input  last_in,
      output ready
   );

endinterface

// File: sv/mwo_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oscillator response channel
// Valid/ready channel that carries one mixed sample per transaction.
// ----------------------------------------------------------------------------
interface mwo_rsp_if;

   logic                                  valid;
   logic                                  ready;
   logic signed [mwo_pkg::SAMPLE_W-1:0]   mix_out;
   logic                                  frame_end;
   logic                                  last_out;

   modport source (
      output valid,
      output mix_out,
      output frame_end,
      output last_out,
      input  ready
   );

   modport sink (
      input  valid,
      input  mix_out,
      input  frame_end,
      input  last_out,
      output ready
   );

endinterface

// File: sv/mwo_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// TableSize+1 entries of round(2^23 * sin(k*pi/(2*TableSize))), built at
// elaboration by an integer Taylor series in Q30; registered read port.
// ----------------------------------------------------------------------------
module mwo_sine_rom #(
   parameter int unsigned TableSize = mwo_pkg::SINE_TABLE_SIZE,
   parameter int unsigned AddrW     = $clog2(TableSize + 1)
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [AddrW-1:0]            rd_addr,
   output logic [mwo_pkg::SINE_W-1:0]  rd_data
);

   typedef logic [mwo_pkg::SINE_W-1:0] rom_type [TableSize+1];

   function automatic rom_type build_rom();
      rom_type            tbl;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] q;
      for (int k = 0; k <= int'(TableSize); k++) begin
         x    = (64'(k) * mwo_pkg::HALF_PI_Q30) / TableSize;
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         // sin(x) = x - x^3/3! + x^5/5! - ... ; divisors are (2n)(2n+1)
         term = ((term * x2) >> 30) / 6;   sum = sum - $signed(term);
         term = ((term * x2) >> 30) / 20;  sum = sum + $signed(term);
         term = ((term * x2) >> 30) / 42;  sum = sum - $signed(term);
         term = ((term * x2) >> 30) / 72;  sum = sum + $signed(term);
         term = ((term * x2) >> 30) / 110; sum = sum - $signed(term);
         term = ((term * x2) >> 30) / 156; sum = sum + $signed(term);
         term = ((term * x2) >> 30) / 210; sum = sum - $signed(term);
         term = ((term * x2) >> 30) / 272; sum = sum + $signed(term);
         if (sum < 0) begin
            sum = 0;
         end
         q = (sum + 64'sd64) >>> 7;
         if (q > mwo_pkg::MAX_Q23_64) begin
            q = mwo_pkg::MAX_Q23_64;
         end
         tbl[k] = q[mwo_pkg::SINE_W-1:0];
      end
      return tbl;
   endfunction

   localparam rom_type SineRom = build_rom();

   logic [mwo_pkg::SINE_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= SineRom[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

// File: sv/multi_waveform_oscillator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-waveform oscillator
// Adds a scaled sine, triangle, falling saw or square tone to an interleaved
// sample stream and saturates the sum to signed 24 bits.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Payload
//   req_if   in         valid / ready      mix_in[23:0] signed, last_in
//   rsp_if   out        valid / ready      mix_out[23:0] signed, frame_end, last_out
//   csr_*    in         write enable only  csr_index[2:0], csr_write_data[30:0]
//
// One transaction per clock sustained while the response is taken. The
// accepting edge loads the input register and the sine ROM word; shape,
// scale, mix and saturate run in one pass, and the response register loads
// that result once it is empty or being emptied.
// The input stalls only while both registers are full and the response is
// not taken; req ready follows rsp ready combinationally.
// Reset (synchronous, active high) clears phase, channel position and both
// valid bits, and loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_waveform_oscillator #(
   parameter int unsigned SineTableSize = mwo_pkg::SINE_TABLE_SIZE,
   parameter int unsigned MaxChannels   = mwo_pkg::MAX_CHANNELS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   mwo_req_if.sink                              req_if,
   mwo_rsp_if.source                            rsp_if,
   input  logic                                 csr_write_enable,
   input  logic [mwo_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mwo_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int unsigned AddrW = $clog2(SineTableSize + 1);
   localparam int unsigned FracW = mwo_pkg::PHASE_W - 2;     // phase within a quadrant
   localparam int unsigned ProdW = FracW + AddrW;
   localparam int unsigned PosW  = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
   localparam int unsigned CmpW  = mwo_pkg::CHAN_CMP_W;

   // Sideband that travels with every sample.
   typedef struct packed {
      logic signed [mwo_pkg::SAMPLE_W-1:0] sample;
      logic                                last;
      logic                                frame_end;
   } side_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [mwo_pkg::STEP_W-1:0] phase_step_ff;
   logic [mwo_pkg::AMP_W-1:0]  amplitude_ff;
   mwo_pkg::wave_type          waveform_ff;
   logic                       tone_enable_ff;
   logic [mwo_pkg::CHAN_W-1:0] channel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff    <= mwo_pkg::PHASE_STEP_RST;
         amplitude_ff     <= mwo_pkg::AMPLITUDE_RST;
         waveform_ff      <= mwo_pkg::WAVE_SINE;
         tone_enable_ff   <= mwo_pkg::TONE_ENABLE_RST;
         channel_count_ff <= mwo_pkg::CHANNEL_COUNT_RST;
      end else if (csr_write_enable) begin
         case (mwo_pkg::csr_index_type'(csr_index))
            mwo_pkg::CSR_PHASE_STEP: begin
               phase_step_ff <= csr_write_data[mwo_pkg::STEP_W-1:0];
            end
            mwo_pkg::CSR_AMPLITUDE: begin
               amplitude_ff <= csr_write_data[mwo_pkg::AMP_W-1:0];
            end
            mwo_pkg::CSR_WAVEFORM: begin
               waveform_ff <= mwo_pkg::wave_type'(csr_write_data[mwo_pkg::WAVE_W-1:0]);
            end
            mwo_pkg::CSR_TONE_ENABLE: begin
               tone_enable_ff <= csr_write_data[0];
            end
            mwo_pkg::CSR_CHANNEL_COUNT: begin
               channel_count_ff <= csr_write_data[mwo_pkg::CHAN_W-1:0];
            end
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Register enables: a register loads when it is empty or the one
   // after it is being emptied.
   // ------------------------------------------------------------------
   logic s1_valid_ff, rsp_valid_ff;
   logic out_en, s1_en;
   logic req_accept;

   assign out_en       = !rsp_valid_ff || rsp_if.ready;
   assign s1_en        = !s1_valid_ff  || out_en;
   assign req_if.ready = s1_en;
   assign req_accept   = req_if.valid && s1_en;

   // ------------------------------------------------------------------
   // Frame counting and phase accumulator, updated on every accepted
   // transaction.
   // ------------------------------------------------------------------
   logic [mwo_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [PosW-1:0]             chan_pos_ff, chan_pos_in;
   logic [CmpW-1:0]             chan_req;
   logic [CmpW-1:0]             chan_limit;
   logic [CmpW-1:0]             pos_next;
   logic                        frame_end_now;

   always_comb begin
      // Clamp the channel count: zero acts as one, large values as the max.
      chan_req = CmpW'(channel_count_ff);
      if (chan_req == '0) begin
         chan_limit = CmpW'(1);
      end else if (chan_req > CmpW'(MaxChannels)) begin
         chan_limit = CmpW'(MaxChannels);
      end else begin
         chan_limit = chan_req;
      end
      // A position at or past the last channel closes the frame, which also
      // covers a count lowered in the middle of a frame.
      pos_next      = CmpW'(chan_pos_ff) + CmpW'(1);
      frame_end_now = (pos_next >= chan_limit);

      chan_pos_in = frame_end_now ? '0 : chan_pos_ff + PosW'(1);
      phase_in    = phase_ff;
      if (frame_end_now && tone_enable_ff) begin
         phase_in = phase_ff + mwo_pkg::PHASE_W'(phase_step_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         chan_pos_ff <= '0;
      end else if (req_accept) begin
         phase_ff    <= phase_in;
         chan_pos_ff <= chan_pos_in;
      end
   end

   // ------------------------------------------------------------------
   // Input register: capture the sample and the current phase, and read
   // the sine ROM on the same edge. Odd quadrants read the table
   // backwards.
   // ------------------------------------------------------------------
   side_type                    s1_side_ff;
   logic [mwo_pkg::PHASE_W-1:0] s1_phase_ff;
   logic [ProdW-1:0]            idx_prod;
   logic [AddrW-1:0]            tbl_idx;
   logic [AddrW-1:0]            rom_addr;
   logic [mwo_pkg::SINE_W-1:0]  rom_data;

   assign idx_prod = ProdW'(phase_ff[FracW-1:0]) * ProdW'(SineTableSize);
   assign tbl_idx  = idx_prod[ProdW-1 -: AddrW];
   assign rom_addr = phase_ff[mwo_pkg::PHASE_W-2]
                   ? AddrW'(SineTableSize) - tbl_idx
                   : tbl_idx;

   mwo_sine_rom #(
      .TableSize (SineTableSize),
      .AddrW     (AddrW)
   ) u_sine_rom (
      .clock   (clock),
      .rd_en   (s1_en),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_side_ff.sample    <= req_if.mix_in;
         s1_side_ff.last      <= req_if.last_in;
         s1_side_ff.frame_end <= frame_end_now;
         s1_phase_ff          <= phase_ff;
      end
   end

   // ------------------------------------------------------------------
   // Single pass: build the oscillator value, scale its magnitude by the
   // amplitude with the rounding half folded in, restore the sign, add to
   // the sample and saturate. With the tone off the sample passes through
   // untouched.
   // ------------------------------------------------------------------
   logic signed [mwo_pkg::VAL_W-1:0]    osc_val;
   logic signed [mwo_pkg::VAL_W-1:0]    osc_abs;
   logic signed [mwo_pkg::VAL_W-1:0]    ramp7;
   logic signed [mwo_pkg::VAL_W-1:0]    ramp8;
   logic signed [mwo_pkg::VAL_W-1:0]    sine_val;
   logic                                first_half;
   logic                                osc_neg;
   logic [mwo_pkg::MAG_W-1:0]           osc_mag;
   logic [mwo_pkg::PROD_W-1:0]          tone_prod;
   logic signed [mwo_pkg::VAL_W-1:0]    tone_scaled;
   logic signed [mwo_pkg::VAL_W-1:0]    mix_sum;
   logic signed [mwo_pkg::SAMPLE_W-1:0] rsp_mix_ff, rsp_mix_in;
   logic                                rsp_frame_end_ff;
   logic                                rsp_last_ff;

   always_comb begin
      ramp7    = $signed(mwo_pkg::VAL_W'(s1_phase_ff[mwo_pkg::PHASE_W-1:7]));
      ramp8    = $signed(mwo_pkg::VAL_W'(s1_phase_ff[mwo_pkg::PHASE_W-1:8]));
      sine_val = $signed(mwo_pkg::VAL_W'(rom_data));
      // Phase up to and including one half cycle counts as the first half.
      first_half = !s1_phase_ff[mwo_pkg::PHASE_W-1]
                || (s1_phase_ff[mwo_pkg::PHASE_W-2:0] == '0);
      case (waveform_ff)
         mwo_pkg::WAVE_SINE: begin
            osc_val = s1_phase_ff[mwo_pkg::PHASE_W-1] ? -sine_val : sine_val;
         end
         mwo_pkg::WAVE_TRIANGLE: begin
            osc_val = first_half ? ramp7 - mwo_pkg::FULL_Q23
                                 : mwo_pkg::TRI_TOP - ramp7;
         end
         mwo_pkg::WAVE_SAW: begin
            osc_val = mwo_pkg::FULL_Q23 - ramp8;
         end
         mwo_pkg::WAVE_SQUARE: begin
            osc_val = first_half ? mwo_pkg::FULL_Q23 : -mwo_pkg::FULL_Q23;
         end
         default: begin
            osc_val = '0;
         end
      endcase
      osc_neg = osc_val[mwo_pkg::VAL_W-1];
      osc_abs = osc_neg ? -osc_val : osc_val;
      osc_mag = osc_abs[mwo_pkg::MAG_W-1:0];

      tone_prod = mwo_pkg::PROD_W'(osc_mag) * mwo_pkg::PROD_W'(amplitude_ff)
                + mwo_pkg::ROUND_HALF;
      tone_scaled = $signed(mwo_pkg::VAL_W'(tone_prod[mwo_pkg::PROD_W-1:16]));
      if (osc_neg) begin
         tone_scaled = -tone_scaled;
      end
      mix_sum = mwo_pkg::VAL_W'(s1_side_ff.sample) + tone_scaled;
      if (!tone_enable_ff) begin
         rsp_mix_in = s1_side_ff.sample;
      end else if (mix_sum > mwo_pkg::SAT_MAX) begin
         rsp_mix_in = mwo_pkg::SAT_MAX[mwo_pkg::SAMPLE_W-1:0];
      end else if (mix_sum < mwo_pkg::SAT_MIN) begin
         rsp_mix_in = mwo_pkg::SAT_MIN[mwo_pkg::SAMPLE_W-1:0];
      end else begin
         rsp_mix_in = mix_sum[mwo_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_mix_ff       <= rsp_mix_in;
         rsp_frame_end_ff <= s1_side_ff.frame_end;
         rsp_last_ff      <= s1_side_ff.last;
      end
   end

   // Valid bits: advance with their register, clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_if.valid;
         end
         if (out_en) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.mix_out   = rsp_mix_ff;
   assign rsp_if.frame_end = rsp_frame_end_ff;
   assign rsp_if.last_out  = rsp_last_ff;

endmodule
